// File: rtl/cls_pkg.sv
// Shared widths, register indexes and coil coding for the cord length stepper drive.
`default_nettype none
package cls_pkg;
  localparam int unsigned COORD_W  = 16;                 // target and config field width
  localparam int unsigned POS_W    = COORD_W + 2;        // signed sum of target and offset
  localparam int unsigned MAG_W    = COORD_W + 1;        // magnitude of a signed position
  localparam int unsigned SQ_W     = 2 * MAG_W;          // one square
  localparam int unsigned ROOT_W   = MAG_W + 1;          // root of a sum of two squares
  localparam int unsigned STEP_W   = 19;
  localparam int unsigned LEN_W    = 18;
  localparam int unsigned COIL_W   = 4;
  localparam int unsigned LENGTH_BITS_DEF = 18;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH = 2'd2;

  typedef logic [1:0] phase_t;
  typedef logic [COIL_W-1:0] coils_t;

  // phase 0..3 drive coils 1, 4, 2, 8
  function automatic coils_t coils_of(input phase_t ph);
    coils_t c;
    unique case (ph)
      2'd0: c = 4'b0001;
      2'd1: c = 4'b0100;
      2'd2: c = 4'b0010;
      2'd3: c = 4'b1000;
      default: c = 4'b0001;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

// File: rtl/cls_if.sv
// Valid/ready channel interfaces for target points and step results.
`default_nettype none
interface cls_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cls_pkg::COORD_W-1:0]   target_x;
  logic signed [cls_pkg::COORD_W-1:0]   target_y;
  modport source (output valid, target_x, target_y, input ready);
  modport sink   (input valid, target_x, target_y, output ready);
endinterface

interface cls_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cls_pkg::STEP_W-1:0]    left_steps;
  logic signed [cls_pkg::STEP_W-1:0]    right_steps;
  logic        [cls_pkg::LEN_W-1:0]     left_length;
  logic        [cls_pkg::LEN_W-1:0]     right_length;
  logic        [cls_pkg::COIL_W-1:0]    left_coils;
  logic        [cls_pkg::COIL_W-1:0]    right_coils;
  modport source (output valid, left_steps, right_steps, left_length, right_length,
                  left_coils, right_coils, input ready);
  modport sink   (input valid, left_steps, right_steps, left_length, right_length,
                  left_coils, right_coils, output ready);
endinterface
`default_nettype wire

// File: rtl/cls_isqrt.sv
// Bit-serial floor square root, one root bit per cycle.
`default_nettype none
module cls_isqrt #(
  parameter int unsigned ROOT_W = cls_pkg::ROOT_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [2*ROOT_W-1:0]   radicand,
  output logic                       done,
  output logic [ROOT_W-1:0]          root
);
  import cls_pkg::*;

  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned CNT_W = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;

  logic [REM_W-1:0] rem_sh, trial;

  // remainder below 2^ROOT_W before each step, so the shifted value fits
  assign rem_sh = {rem_r[ROOT_W-1:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(ROOT_W - 1);
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

// File: rtl/cord_length_stepper_drive.sv
// Top level: target point to cord lengths, step counts and coil patterns.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        target_x, target_y
//   out_ch   out  valid/ready        left/right steps, lengths, coils
//   cfg_*    in   cfg_we only        cfg_index, cfg_data
//
// Each item goes from its transfer to the next ready through the transfer cycle,
// magnitudes and the first two squares on one shared 17x17 multiplier,
// a pass per cord through the root unit (start, 18 root bits, done; the left start
// also takes the last square), and the commit, which waits for a free output register.
// in_ch.ready is high only while no item is in work; a result waiting in the
// output register does not block acceptance, only the final commit.
// rst_n is synchronous; it clears cords, phases, control and config registers.
`default_nettype none
module cord_length_stepper_drive #(
  parameter int unsigned LENGTH_BITS = cls_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  cls_in_if.sink                                 in_ch,
  cls_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [cls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cls_pkg::COORD_W-1:0]       cfg_data
);
  import cls_pkg::*;

  localparam int unsigned CW = (LENGTH_BITS > ROOT_W) ? LENGTH_BITS : ROOT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ABS  = 4'd1;
  localparam logic [3:0] S_MY   = 4'd2;
  localparam logic [3:0] S_MX   = 4'd3;
  localparam logic [3:0] S_SL   = 4'd4;
  localparam logic [3:0] S_WL   = 4'd5;
  localparam logic [3:0] S_SR   = 4'd6;
  localparam logic [3:0] S_WR   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_r, state_nxt;

  logic [COORD_W-1:0] origin_x_r, origin_y_r, base_length_r;

  logic signed [POS_W-1:0] x_r, y_r;
  logic [MAG_W-1:0]        ax_r, ay_r, axr_r;
  logic [SQ_W-1:0]         prod_r, sqy_r;
  logic [ROOT_W-1:0]       lroot_r;

  logic [LENGTH_BITS-1:0]  left_cord_r, right_cord_r;
  phase_t                  left_phase_r, right_phase_r;

  logic                    out_valid_r;
  logic [STEP_W-1:0]       left_steps_r, right_steps_r;
  logic [LEN_W-1:0]        left_length_r, right_length_r;
  coils_t                  left_coils_r, right_coils_r;

  logic                    in_xfer, commit;
  logic [MAG_W-1:0]        mul_a;
  logic [SQ_W-1:0]         mul_p;
  logic                    sq_start, sq_done;
  logic [2*ROOT_W-1:0]     sq_rad;
  logic [ROOT_W-1:0]       sq_root;

  logic signed [POS_W-1:0] x_sum, y_sum, xr_diff;
  logic [POS_W-1:0]        x_abs, y_abs, xr_abs;

  logic [CW-1:0]           lim, l_ext, r_ext, l_new, r_new;
  logic [CW:0]             dl, dr;
  phase_t                  lph_nxt, rph_nxt;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign commit      = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // offset add on the accept cycle, magnitudes in the cycle after it
  assign x_sum   = POS_W'(in_ch.target_x) + $signed({2'b00, origin_x_r});
  assign y_sum   = POS_W'(in_ch.target_y) + $signed({2'b00, origin_y_r});
  assign xr_diff = $signed({2'b00, base_length_r}) - x_r;
  assign x_abs   = x_r[POS_W-1]     ? POS_W'(-x_r)     : POS_W'(x_r);
  assign y_abs   = y_r[POS_W-1]     ? POS_W'(-y_r)     : POS_W'(y_r);
  assign xr_abs  = xr_diff[POS_W-1] ? POS_W'(-xr_diff) : POS_W'(xr_diff);

  // shared squarer
  always_comb begin
    unique case (state_r)
      S_MY:    mul_a = ay_r;
      S_MX:    mul_a = ax_r;
      default: mul_a = axr_r;
    endcase
  end
  assign mul_p = mul_a * mul_a;

  assign sq_start = (state_r == S_SL) || (state_r == S_SR);
  assign sq_rad   = (2*ROOT_W)'(sqy_r) + (2*ROOT_W)'(prod_r);

  cls_isqrt #(.ROOT_W(ROOT_W)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  // clamp to the cord width, then differences and phases
  assign lim   = CW'({LENGTH_BITS{1'b1}});
  assign l_ext = CW'(lroot_r);
  assign r_ext = CW'(sq_root);
  assign l_new = (l_ext > lim) ? lim : l_ext;
  assign r_new = (r_ext > lim) ? lim : r_ext;
  assign dl    = {1'b0, l_new} - {1'b0, CW'(left_cord_r)};
  assign dr    = {1'b0, r_new} - {1'b0, CW'(right_cord_r)};
  assign lph_nxt = left_phase_r + dl[1:0];
  assign rph_nxt = right_phase_r + dr[1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_ABS;
      S_ABS:  state_nxt = S_MY;
      S_MY:   state_nxt = S_MX;
      S_MX:   state_nxt = S_SL;
      S_SL:   state_nxt = S_WL;
      S_WL:   if (sq_done) state_nxt = S_SR;
      S_SR:   state_nxt = S_WR;
      S_WR:   if (sq_done) state_nxt = S_FIN;
      S_FIN:  if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      base_length_r <= '0;
      left_cord_r   <= '0;
      right_cord_r  <= '0;
      left_phase_r  <= '0;
      right_phase_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ORIGIN_X:    origin_x_r    <= cfg_data;
          REG_ORIGIN_Y:    origin_y_r    <= cfg_data;
          REG_BASE_LENGTH: base_length_r <= cfg_data;
          default: ;
        endcase
      end
      if (commit) begin
        left_cord_r   <= l_new[LENGTH_BITS-1:0];
        right_cord_r  <= r_new[LENGTH_BITS-1:0];
        left_phase_r  <= lph_nxt;
        right_phase_r <= rph_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r <= x_sum;
      y_r <= y_sum;
    end
    if (state_r == S_ABS) begin
      ax_r  <= x_abs[MAG_W-1:0];
      ay_r  <= y_abs[MAG_W-1:0];
      axr_r <= xr_abs[MAG_W-1:0];
    end
    if (state_r == S_MY || state_r == S_MX || state_r == S_SL) prod_r <= mul_p;
    if (state_r == S_MX) sqy_r <= prod_r;
    if (state_r == S_WL && sq_done) lroot_r <= sq_root;
    if (commit) begin
      left_steps_r   <= dl[STEP_W-1:0];
      right_steps_r  <= dr[STEP_W-1:0];
      left_length_r  <= l_new[LEN_W-1:0];
      right_length_r <= r_new[LEN_W-1:0];
      left_coils_r   <= coils_of(lph_nxt);
      right_coils_r  <= coils_of(rph_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.left_steps   = left_steps_r;
  assign out_ch.right_steps  = right_steps_r;
  assign out_ch.left_length  = left_length_r;
  assign out_ch.right_length = right_length_r;
  assign out_ch.left_coils   = left_coils_r;
  assign out_ch.right_coils  = right_coils_r;
endmodule
`default_nettype wire

// File: rtl/cls_checker.sv
// Port-level checks for the cord length stepper drive, bound to the top level.
`default_nettype none
module cls_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [cls_pkg::STEP_W-1:0]    left_steps,
  input wire logic [cls_pkg::LEN_W-1:0]     left_length,
  input wire logic [cls_pkg::COIL_W-1:0]    left_coils,
  input wire logic [cls_pkg::COIL_W-1:0]    right_coils
);
  import cls_pkg::*;

  // a held result stays put until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_steps) && $stable(left_length))
    else $error("result changed while stalled");

  // one item in work at a time
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  a_coils: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(left_coils) && $onehot(right_coils))
    else $error("coil pattern not one-hot");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind cord_length_stepper_drive cls_checker u_cls_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .left_steps  (out_ch.left_steps),
  .left_length (out_ch.left_length),
  .left_coils  (out_ch.left_coils),
  .right_coils (out_ch.right_coils)
);
`default_nettype wire

// File: verif/tb_cord_length_stepper_drive.sv
`timescale 1ns / 100ps
// Testbench for cord_length_stepper_drive: target points in, step counts and coils checked.
module tb_cord_length_stepper_drive;
  import cls_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 60;
  localparam int unsigned SWEEP_PHASES   = 8;
  localparam int unsigned SWEEP_POINTS   = 200;
  localparam int unsigned RX_OPEN        = 0;
  localparam int unsigned RX_COIN        = 1;
  localparam int unsigned RX_TRICKLE     = 2;
  // index 3 has no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct {
    logic signed [STEP_W-1:0] left_steps;
    logic signed [STEP_W-1:0] right_steps;
    logic [LEN_W-1:0]         left_length;
    logic [LEN_W-1:0]         right_length;
    coils_t                   left_coils;
    coils_t                   right_coils;
  } cord_move_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;

  cls_in_if  in_ch ();
  cls_out_if out_ch ();

  cord_length_stepper_drive dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the block's registers and motor state
  logic [COORD_W-1:0] origin_x_q;
  logic [COORD_W-1:0] origin_y_q;
  logic [COORD_W-1:0] base_len_q;
  logic [LEN_W-1:0]   left_cord_q;
  logic [LEN_W-1:0]   right_cord_q;
  phase_t             left_phase_q;
  phase_t             right_phase_q;

  cord_move_t         moves_due[$];
  cord_move_t         due_move;
  int unsigned        errors;
  int unsigned        burst_left;
  logic [COORD_W-1:0] last_x;
  logic [COORD_W-1:0] last_y;

  // greedy bit-by-bit root; stopping at LEN_W bits also clamps to the max length
  function automatic logic [LEN_W-1:0] floor_root(input longint unsigned sum_sq);
    logic [LEN_W-1:0] r;
    logic [LEN_W-1:0] cand;
    longint unsigned  trial;
    r = '0;
    for (int b = LEN_W - 1; b >= 0; b--) begin
      cand = r;
      cand[b] = 1'b1;
      trial = longint'(cand);
      if (trial * trial <= sum_sq) r = cand;
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] cord_span(input longint dx, input longint dy);
    return floor_root(dx * dx + dy * dy);
  endfunction

  function automatic coils_t coil_drive(input phase_t ph);
    case (ph)
      2'd0: return 4'b0001;
      2'd1: return 4'b0100;
      2'd2: return 4'b0010;
      default: return 4'b1000;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] corner_coord(input int unsigned sel);
    case (sel)
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic predict_move(input logic signed [COORD_W-1:0] tx,
                              input logic signed [COORD_W-1:0] ty);
    longint           px;
    longint           py;
    longint           dl;
    longint           dr;
    logic [LEN_W-1:0] new_left;
    logic [LEN_W-1:0] new_right;
    cord_move_t       m;
    px = longint'(tx) + longint'(origin_x_q);
    py = longint'(ty) + longint'(origin_y_q);
    new_left  = cord_span(px, py);
    new_right = cord_span(longint'(base_len_q) - px, py);
    dl = longint'(new_left) - longint'(left_cord_q);
    dr = longint'(new_right) - longint'(right_cord_q);
    left_phase_q  = left_phase_q + dl[1:0];
    right_phase_q = right_phase_q + dr[1:0];
    left_cord_q   = new_left;
    right_cord_q  = new_right;
    m.left_steps   = dl[STEP_W-1:0];
    m.right_steps  = dr[STEP_W-1:0];
    m.left_length  = new_left;
    m.right_length = new_right;
    m.left_coils   = coil_drive(left_phase_q);
    m.right_coils  = coil_drive(right_phase_q);
    moves_due.push_back(m);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_ORIGIN_X:    origin_x_q = val;
      REG_ORIGIN_Y:    origin_y_q = val;
      REG_BASE_LENGTH: base_len_q = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                           input logic [COORD_W-1:0] base);
    set_reg(REG_ORIGIN_X, ox);
    set_reg(REG_ORIGIN_Y, oy);
    set_reg(REG_BASE_LENGTH, base);
  endtask

  // entered at a clock edge; returns at the edge of the transfer
  task automatic send_point(input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid    <= 1'b1;
    in_ch.target_x <= tx;
    in_ch.target_y <= ty;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_move(tx, ty);
    last_x = tx;
    last_y = ty;
    burst_left--;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (moves_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_point(16'd0, 16'd0);
    send_point(16'd3, 16'd4);
    send_point(-16'sd3, -16'sd4);  // negative sums, same cord, no step
    send_point(16'h7FFF, 16'h7FFF);
    send_point(16'h8000, 16'h8000);
    send_point(16'h8000, 16'h7FFF);
    send_point(16'd0, 16'd0);
  endtask

  task automatic test_register_extremes();
    drain_results();
    set_reg(REG_NONE, 16'hFFFF);
    send_point(16'd5, 16'd12);
    drain_results();
    configure(16'hFFFF, 16'hFFFF, 16'h0000);
    send_point(16'h7FFF, 16'h7FFF);
    send_point(16'h8000, 16'h8000);
    send_point(16'd0, 16'd0);
    send_point(16'hFFFF, 16'hFFFF);
    drain_results();
    configure(16'h0000, 16'h0000, 16'hFFFF);
    send_point(16'h8000, 16'd0);
    send_point(16'h7FFF, 16'h8000);
    send_point(16'd100, 16'd100);
  endtask

  // single steps back and forth walk the coil phase both ways
  task automatic test_step_phases();
    drain_results();
    configure(16'd1000, 16'd2000, 16'd3000);
    send_point(16'd0, 16'd0);
    send_point(16'd1, 16'd0);
    send_point(16'd2, 16'd0);
    send_point(16'd3, 16'd0);
    send_point(16'd3, 16'd0);
    send_point(16'd2, 16'd0);
    send_point(16'd0, 16'd0);
  endtask

  task automatic test_random_sweep();
    int unsigned        sel;
    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] ty;
    for (int unsigned ph = 0; ph < SWEEP_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: configure(16'h0000, 16'h0000, 16'h0000);
        1: configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: configure(16'h0000, 16'hFFFF, 16'hFFFF);
        default: configure(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
      endcase
      if ($urandom_range(0, 1) == 1) set_reg(REG_NONE, COORD_W'($urandom));
      for (int unsigned n = 0; n < SWEEP_POINTS; n++) begin
        if (n == SWEEP_POINTS / 2 && ph % 3 == 0) drain_results();
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
          tx = COORD_W'($urandom);
          ty = COORD_W'($urandom);
        end else if (sel < 8) begin
          tx = COORD_W'(last_x + $urandom_range(0, 8) - 4);
          ty = COORD_W'(last_y + $urandom_range(0, 8) - 4);
        end else if (sel == 8) begin
          tx = last_x;
          ty = last_y;
        end else begin
          tx = corner_coord($urandom_range(0, 3));
          ty = corner_coord($urandom_range(0, 3));
        end
        send_point(tx, ty);
      end
    end
  endtask

  task automatic check_field(input string name, input logic signed [STEP_W-1:0] exp_v,
                             input logic signed [STEP_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (moves_due.size() == 0) begin
        $display("%0t: result with none expected: steps %0d/%0d lengths %0d/%0d",
                 $time, out_ch.left_steps, out_ch.right_steps,
                 out_ch.left_length, out_ch.right_length);
        errors++;
      end else begin
        due_move = moves_due.pop_front();
        check_field("left_steps", due_move.left_steps, out_ch.left_steps);
        check_field("right_steps", due_move.right_steps, out_ch.right_steps);
        check_field("left_length", STEP_W'(due_move.left_length),
                    STEP_W'(out_ch.left_length));
        check_field("right_length", STEP_W'(due_move.right_length),
                    STEP_W'(out_ch.right_length));
        check_field("left_coils", STEP_W'(due_move.left_coils),
                    STEP_W'(out_ch.left_coils));
        check_field("right_coils", STEP_W'(due_move.right_coils),
                    STEP_W'(out_ch.right_coils));
      end
    end
  end

  // receiver: open stretches, coin-flip stalls and long holds
  int unsigned rx_mode = RX_OPEN;
  int unsigned rx_cycles_left = 0;
  always @(posedge clk) begin
    if (rx_cycles_left == 0) begin
      rx_mode        <= $urandom_range(RX_OPEN, RX_TRICKLE);
      rx_cycles_left <= $urandom_range(50, 400);
    end else begin
      rx_cycles_left <= rx_cycles_left - 1;
    end
    case (rx_mode)
      RX_OPEN: out_ch.ready <= 1'b1;
      RX_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
      default: out_ch.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("tb_cord_length_stepper_drive: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_ORIGIN_X;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.target_x <= '0;
    in_ch.target_y <= '0;
    origin_x_q    = '0;
    origin_y_q    = '0;
    base_len_q    = '0;
    left_cord_q   = '0;
    right_cord_q  = '0;
    left_phase_q  = '0;
    right_phase_q = '0;
    errors        = 0;
    burst_left    = 0;
    last_x        = '0;
    last_y        = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_register_extremes();
    test_step_phases();
    test_random_sweep();
    drain_results();
    if (errors == 0) begin
      $display("tb_cord_length_stepper_drive: PASS");
    end else begin
      $display("tb_cord_length_stepper_drive: FAIL");
    end
    $finish;
  end

endmodule

// File: cord_length_stepper_drive.f
rtl/cls_pkg.sv
rtl/cls_if.sv
rtl/cls_isqrt.sv
rtl/cord_length_stepper_drive.sv
rtl/cls_checker.sv
verif/tb_cord_length_stepper_drive.sv
